// ----- hdl/rle_pkg.sv -----
// Shared types and constants for the byte run-length encoder.
`default_nettype none

package rle_pkg;

    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned LENGTH_W = 16;

    localparam logic [LENGTH_W-1:0] MAX_RUN_RESET = 16'd32766;

    // Record queue depth; an item may push two records while one is popped.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                last;
        logic [LENGTH_W-1:0] length;
        logic [VALUE_W-1:0]  value;
    } t_record;

    // Which of the two record slots an accepted byte fills.
    typedef struct packed {
        logic closed;
        logic flush;
    } t_push;

endpackage

`default_nettype wire

// ----- hdl/rle_core.sv -----
// Run tracker: holds the open run and forms the closed and flushed records.
`default_nettype none

module rle_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rle_pkg::LENGTH_W-1:0]   i_cfg_wdata,
    input  wire logic                           i_accept,
    input  wire logic [rle_pkg::VALUE_W-1:0]    i_byte,
    input  wire logic                           i_eos,
    output rle_pkg::t_push                      o_push,
    output rle_pkg::t_record                    o_closed_rec,
    output rle_pkg::t_record                    o_flush_rec
);
    import rle_pkg::*;

    logic [LENGTH_W-1:0] r_max_run;
    logic [VALUE_W-1:0]  r_cur_value;
    logic [LENGTH_W-1:0] r_run_count;
    logic [VALUE_W-1:0]  n_cur_value;
    logic [LENGTH_W-1:0] n_run_count;
    logic                close_run;
    logic [LENGTH_W-1:0] new_count;

    // An open run closes on a new value or once it has reached the limit.
    assign close_run = (r_run_count != '0) &&
                       ((i_byte != r_cur_value) || (r_run_count >= r_max_run));
    assign new_count = close_run ? LENGTH_W'(1) : r_run_count + LENGTH_W'(1);

    assign o_push.closed = i_accept && close_run;
    assign o_push.flush  = i_accept && i_eos;

    assign o_closed_rec = '{last: 1'b0, length: r_run_count, value: r_cur_value};
    assign o_flush_rec  = '{last: 1'b1, length: new_count,   value: i_byte};

    always_comb begin
        n_cur_value = r_cur_value;
        n_run_count = r_run_count;
        if (i_accept) begin
            if (i_eos) begin
                n_cur_value = '0;
                n_run_count = '0;
            end else begin
                n_cur_value = i_byte;
                n_run_count = new_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run   <= MAX_RUN_RESET;
            r_cur_value <= '0;
            r_run_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_run <= i_cfg_wdata;
            end
            r_cur_value <= n_cur_value;
            r_run_count <= n_run_count;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rle_queue.sv -----
// Record queue: takes up to two records a cycle, hands out one while the reader is ready.
`default_nettype none

module rle_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rle_pkg::t_push     i_push,
    input  wire rle_pkg::t_record   i_closed_rec,
    input  wire rle_pkg::t_record   i_flush_rec,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_pop_ready,
    output rle_pkg::t_record        o_rec
);
    import rle_pkg::*;

    t_record           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] flush_ptr;
    logic              pop;
    logic [QCNT_W-1:0] push_cnt;

    // The flush record lands after the closed record when both are pushed.
    assign flush_ptr = r_wr_ptr + QPTR_W'(i_push.closed);
    assign pop       = o_valid && i_pop_ready;
    assign push_cnt  = QCNT_W'(i_push.closed) + QCNT_W'(i_push.flush);

    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    // Room for two records keeps one word per cycle flowing on both sides while the reader is ready.
    assign o_room  = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.closed) begin
            r_mem[r_wr_ptr] <= i_closed_rec;
        end
        if (i_push.flush) begin
            r_mem[flush_ptr] <= i_flush_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(push_cnt);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(pop);
            r_count  <= r_count + push_cnt - QCNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/byte_run_length_encoder.sv -----
// Byte run-length encoder top level: run tracker feeding a record queue.
//
//  channel   direction  tdata                                tlast
//  s_axis    in         [7:0] data_byte                      end_of_stream
//  m_axis    out        [7:0] run_value, [23:8] run_length   last_record
//  cfg       in         [15:0] max_run (write only)          -
//
// One byte word is accepted per cycle unless stalled; its records enter the
// output queue at the same edge and the first can leave on the next cycle. A
// final byte that also closes a run adds two records, so the output side sets the
// sustained rate through the four-entry queue. Input ready drops only while fewer
// than two queue entries are free. Reset is synchronous and clears the open run.
`default_nettype none

module byte_run_length_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,     // [15:0] max_run
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,    // [7:0] run_value, [23:8] run_length
    output logic             m_axis_tlast
);
    import rle_pkg::*;

    t_push   push;
    t_record closed_rec;
    t_record flush_rec;
    t_record head_rec;
    logic    room;
    logic    accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    rle_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .i_eos        (s_axis_tlast),
        .o_push       (push),
        .o_closed_rec (closed_rec),
        .o_flush_rec  (flush_rec)
    );

    rle_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_closed_rec (closed_rec),
        .i_flush_rec  (flush_rec),
        .o_room       (room),
        .o_valid      (m_axis_tvalid),
        .i_pop_ready  (m_axis_tready),
        .o_rec        (head_rec)
    );

    assign m_axis_tdata = {head_rec.length, head_rec.value};
    assign m_axis_tlast = head_rec.last;

endmodule

`default_nettype wire
